>>> rtl/median_filter_3x3_stream_assert.svh
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_STREAM_ASSERT_SVH
`define MEDIAN_FILTER_3X3_STREAM_ASSERT_SVH

// Expression holds at every clock edge outside reset.
`define MF3_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define MF3_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MF3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mf3_pkg.sv
// Shared constants and types of the 3x3 median filter.
package mf3_pkg;

   localparam int TAPS           = 9;
   localparam int QUEUE_DEPTH    = 4;
   localparam int WIDTH_REG_BITS = 12;
   localparam int ROW_BITS       = 13;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 13;
   localparam int HEIGHT_LIMIT   = 4096;
   localparam int WIDTH_RESET    = 512;
   localparam int HEIGHT_RESET   = 512;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);

   // Per-beat classification carried from the counter stage to the window stage.
   typedef struct packed {
      logic row_ge1;
      logic row_ge2;
      logic emit;
      logic first_col;
      logic last_col;
      logic img_end;
   } front_ctl_type;

endpackage

>>> rtl/mf3_req_if.sv
// Pixel input channel: valid/ready with pixel payload.
interface mf3_req_if #(parameter int PIXEL_BITS = 8);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_value;
   logic                  flush_item;

   modport source (output valid, output pixel_value, output flush_item, input ready);
   modport sink   (input valid, input pixel_value, input flush_item, output ready);
endinterface

>>> rtl/mf3_rsp_if.sv
// Median result channel: valid/ready with median payload.
interface mf3_rsp_if #(parameter int PIXEL_BITS = 8);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] median_value;
   logic                  last_of_image;

   modport source (output valid, output median_value, output last_of_image, input ready);
   modport sink   (input valid, input median_value, input last_of_image, output ready);
endinterface

>>> rtl/mf3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/mf3_front.sv
// Front end: position counters, line store and 3x3 window shift.
`include "median_filter_3x3_stream_assert.svh"
module mf3_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   mf3_req_if.sink                                       req_bus,
   input  logic                                          csr_write_enable,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0]            csr_index,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]             csr_write_data,
   output logic                                          win_valid,
   input  logic                                          win_ready,
   output logic [mf3_pkg::TAPS-1:0][PIXEL_BITS-1:0]      win_taps,
   output logic                                          win_last
);
   import mf3_pkg::*;

   localparam int CW      = $clog2(MAX_WIDTH + 1);
   localparam int AW      = $clog2(MAX_WIDTH);
   localparam int PB      = PIXEL_BITS;
   localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

   logic [CW-1:0]        wid_ff, wid_in, w_cfg;
   logic [ROW_BITS-1:0]  hgt_ff, hgt_in, h_cfg;
   logic [CW-1:0]        col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [WIDTH_REG_BITS-1:0] raw_w;
   logic [ROW_BITS-1:0]  raw_h;

   logic                 s1_v_ff, s1_v_in;
   logic [PB-1:0]        s1_pix_ff;
   logic [AW-1:0]        s1_addr_ff;
   front_ctl_type        s1_ctl_ff, ctl_new;
   logic                 fwd_ff, fwd_in;
   logic [2*PB-1:0]      fwd_data_ff;
   logic [TAPS-1:0][PB-1:0] taps_ff, taps_in;

   logic                 accept, s1_adv, is_c0, row_end;
   logic [PB-1:0]        pix_new, mid_m, top_m;
   logic [AW-1:0]        rd_addr;
   logic [2*PB-1:0]      ram_rd, rd_word, wr_word;

   // Effective geometry from a register write: zero acts as one, clamp at the top.
   assign raw_w = csr_write_data[WIDTH_REG_BITS-1:0];
   assign raw_h = csr_write_data[ROW_BITS-1:0];

   always_comb begin
      if (raw_w == '0) begin
         w_cfg = CW'(1);
      end else if (32'(raw_w) > MAX_WIDTH) begin
         w_cfg = CW'(MAX_WIDTH);
      end else begin
         w_cfg = CW'(raw_w);
      end
      if (raw_h == '0) begin
         h_cfg = ROW_BITS'(1);
      end else if (32'(raw_h) > HEIGHT_LIMIT) begin
         h_cfg = ROW_BITS'(HEIGHT_LIMIT);
      end else begin
         h_cfg = raw_h;
      end
   end

   // Classify the incoming beat by its raster position.
   assign is_c0   = (col_ff == '0);
   assign row_end = (row_ff == hgt_ff + ROW_BITS'(1));
   assign rd_addr = col_ff[AW-1:0];

   always_comb begin
      ctl_new.row_ge1   = (row_ff != '0);
      ctl_new.row_ge2   = (row_ff >= ROW_BITS'(2));
      ctl_new.last_col  = is_c0;
      ctl_new.first_col = (col_ff == CW'(1)) || (is_c0 && (wid_ff == CW'(1)));
      ctl_new.img_end   = is_c0 && row_end;
      if (is_c0) begin
         ctl_new.emit = ctl_new.row_ge2 && ((row_ff <= hgt_ff) || row_end);
      end else begin
         ctl_new.emit = ctl_new.row_ge1 && (row_ff <= hgt_ff);
      end
      if (req_bus.flush_item || (row_ff >= hgt_ff)) begin
         pix_new = '0;
      end else begin
         pix_new = req_bus.pixel_value;
      end
   end

   assign s1_adv        = s1_v_ff && (!s1_ctl_ff.emit || win_ready);
   assign req_bus.ready = !s1_v_ff || s1_adv;
   assign accept        = req_bus.valid && req_bus.ready;

   // Counters and geometry registers.
   always_comb begin
      wid_in = wid_ff;
      hgt_in = hgt_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_ff == wid_ff - CW'(1)) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               wid_in = w_cfg;
               col_in = '0;
               row_in = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               hgt_in = h_cfg;
               col_in = '0;
               row_in = '0;
            end
            default: begin
               wid_in = wid_ff;
            end
         endcase
      end
   end

   // Line store word: upper row in the high half, middle row in the low half.
   mf3_ram #(
      .WIDTH (2 * PB),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   // A write from the leaving beat to the address read this cycle is missed by the RAM.
   assign rd_word = fwd_ff ? fwd_data_ff : ram_rd;
   assign mid_m   = s1_ctl_ff.row_ge1 ? rd_word[PB-1:0] : '0;
   assign top_m   = s1_ctl_ff.row_ge2 ? rd_word[2*PB-1:PB] : '0;
   assign wr_word = {mid_m, s1_pix_ff};

   always_comb begin
      fwd_in  = fwd_ff;
      s1_v_in = s1_v_ff;
      if (accept) begin
         fwd_in  = s1_adv && (s1_addr_ff == rd_addr);
         s1_v_in = 1'b1;
      end else if (s1_adv) begin
         s1_v_in = 1'b0;
      end
   end

   // Shift the window by one column.
   always_comb begin
      for (int i = 0; i < TAPS - 3; i++) begin
         taps_in[i] = taps_ff[i + 3];
      end
      taps_in[TAPS-3] = top_m;
      taps_in[TAPS-2] = mid_m;
      taps_in[TAPS-1] = s1_pix_ff;
   end

   always_comb begin
      win_taps = taps_in;
      if (s1_ctl_ff.first_col) begin
         win_taps[0] = '0;
         win_taps[1] = '0;
         win_taps[2] = '0;
      end
      if (s1_ctl_ff.last_col) begin
         win_taps[TAPS-3] = '0;
         win_taps[TAPS-2] = '0;
         win_taps[TAPS-1] = '0;
      end
   end

   assign win_valid = s1_v_ff && s1_ctl_ff.emit;
   assign win_last  = s1_ctl_ff.img_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff  <= CW'(W_RESET);
         hgt_ff  <= ROW_BITS'(HEIGHT_RESET);
         col_ff  <= '0;
         row_ff  <= '0;
         s1_v_ff <= 1'b0;
         fwd_ff  <= 1'b0;
         taps_ff <= '0;
      end else begin
         wid_ff  <= wid_in;
         hgt_ff  <= hgt_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         s1_v_ff <= s1_v_in;
         fwd_ff  <= fwd_in;
         if (s1_adv) begin
            taps_ff <= taps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= pix_new;
         s1_addr_ff  <= rd_addr;
         s1_ctl_ff   <= ctl_new;
         fwd_data_ff <= wr_word;
      end
   end

   `MF3_ASSERT_ALWAYS(a_col_in_range, col_ff < wid_ff, "column counter beyond image width")
   `MF3_ASSERT_ALWAYS(a_row_in_range, row_ff <= hgt_ff + ROW_BITS'(1), "row counter past padding")
   `MF3_ASSERT_IMPLY(a_end_emits, s1_v_ff && s1_ctl_ff.img_end, s1_ctl_ff.emit, "image end without result")
endmodule

>>> rtl/mf3_queue.sv
// Short FIFO between the window front end and the median back end.
`include "median_filter_3x3_stream_assert.svh"
module mf3_queue #(
   parameter int WIDTH = 73
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import mf3_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != NW'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   `MF3_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + NW'(1), "queue count lost a push")
endmodule

>>> rtl/mf3_median.sv
// Back end: three-stage median-of-nine network with output register.
module mf3_median #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [mf3_pkg::TAPS-1:0][PIXEL_BITS-1:0] in_taps,
   input  logic                                     in_last,
   mf3_rsp_if.source                                rsp_bus
);
   import mf3_pkg::*;

   localparam int PB = PIXEL_BITS;

   function automatic logic [PB-1:0] min2(input logic [PB-1:0] a, input logic [PB-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PB-1:0] max2(input logic [PB-1:0] a, input logic [PB-1:0] b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic [PB-1:0] med3(input logic [PB-1:0] a, input logic [PB-1:0] b,
                                          input logic [PB-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Stage A: each group of three sorted into low, middle, high.
   logic              a_v_ff, a_v_in, a_last_ff;
   logic [2:0][PB-1:0] a_lo_ff, a_md_ff, a_hi_ff, a_lo_in, a_md_in, a_hi_in;
   // Stage B: max of lows, median of middles, min of highs.
   logic              b_v_ff, b_v_in, b_last_ff;
   logic [PB-1:0]     b_l_ff, b_m_ff, b_h_ff;
   // Stage C: output register.
   logic              c_v_ff, c_v_in, c_last_ff;
   logic [PB-1:0]     c_med_ff;

   logic a_ready, b_ready, c_ready, a_load, b_load, c_load;

   assign c_ready  = !c_v_ff || rsp_bus.ready;
   assign b_ready  = !b_v_ff || c_ready;
   assign a_ready  = !a_v_ff || b_ready;
   assign in_ready = a_ready;
   assign a_load   = in_valid && a_ready;
   assign b_load   = a_v_ff && b_ready;
   assign c_load   = b_v_ff && c_ready;

   always_comb begin
      for (int g = 0; g < 3; g++) begin
         a_lo_in[g] = min2(min2(in_taps[3*g], in_taps[3*g+1]), in_taps[3*g+2]);
         a_hi_in[g] = max2(max2(in_taps[3*g], in_taps[3*g+1]), in_taps[3*g+2]);
         a_md_in[g] = med3(in_taps[3*g], in_taps[3*g+1], in_taps[3*g+2]);
      end
   end

   always_comb begin
      a_v_in = a_load ? 1'b1 : (b_load ? 1'b0 : a_v_ff);
      b_v_in = b_load ? 1'b1 : (c_load ? 1'b0 : b_v_ff);
      c_v_in = c_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : c_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         c_v_ff <= c_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_lo_ff   <= a_lo_in;
         a_md_ff   <= a_md_in;
         a_hi_ff   <= a_hi_in;
         a_last_ff <= in_last;
      end
      if (b_load) begin
         b_l_ff    <= max2(max2(a_lo_ff[0], a_lo_ff[1]), a_lo_ff[2]);
         b_m_ff    <= med3(a_md_ff[0], a_md_ff[1], a_md_ff[2]);
         b_h_ff    <= min2(min2(a_hi_ff[0], a_hi_ff[1]), a_hi_ff[2]);
         b_last_ff <= a_last_ff;
      end
      if (c_load) begin
         c_med_ff  <= med3(b_l_ff, b_m_ff, b_h_ff);
         c_last_ff <= b_last_ff;
      end
   end

   assign rsp_bus.valid         = c_v_ff;
   assign rsp_bus.median_value  = c_med_ff;
   assign rsp_bus.last_of_image = c_last_ff;
endmodule

>>> rtl/median_filter_3x3_stream.sv
// A beat's window passes the queue and median stages A and B into the result register;
// the median of a position appears once the beat one row plus one pixel later is taken.
// Throughput: one beat per cycle unless the queue is full, set by the 1R1W line store RAM.
// Reset clears counters, pipeline valids, queue and window; width and height return to 512.
// The line store is not cleared: each entry is written in a row before it is read.
// Top level of the streaming 3x3 median filter.
module median_filter_3x3_stream #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   mf3_req_if.sink                            req_bus,
   mf3_rsp_if.source                          rsp_bus,
   input  logic                               csr_write_enable,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import mf3_pkg::*;

   localparam int QW = TAPS * PIXEL_BITS + 1;

   logic                              win_valid, win_ready, win_last;
   logic [TAPS-1:0][PIXEL_BITS-1:0]   win_taps, q_taps;
   logic                              q_valid, q_ready, q_last;
   logic [QW-1:0]                     q_out;

   mf3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .win_valid        (win_valid),
      .win_ready        (win_ready),
      .win_taps         (win_taps),
      .win_last         (win_last)
   );

   mf3_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_ready  (win_ready),
      .in_data   ({win_last, win_taps}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_out)
   );

   assign q_last = q_out[QW-1];
   assign q_taps = q_out[QW-2:0];

   mf3_median #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_median (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_taps  (q_taps),
      .in_last  (q_last),
      .rsp_bus  (rsp_bus)
   );
endmodule

>>> sim/median_stream_checker.sv
// Checker for the 3x3 median filter: predicts every median beat and compares the result channel.
module median_stream_checker #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   mf3_req_if                                 req_tap,
   mf3_rsp_if                                 rsp_tap,
   input  logic                               csr_write_enable,
   input  logic [mf3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output int                                 outstanding,
   output int                                 mismatch_count
);
   import mf3_pkg::*;

   typedef struct packed {
      logic [7:0] median_value;
      logic       last_of_image;
   } median_beat_type;

   median_beat_type           median_queue[$];
   logic [7:0]                upper_row  [MAX_WIDTH];
   logic [7:0]                middle_row [MAX_WIDTH];
   logic [7:0]                window     [TAPS];
   logic [WIDTH_REG_BITS-1:0] width_reg;
   logic [ROW_BITS-1:0]       height_reg;
   int                        col_pos;
   int                        row_pos;
   int                        errors = 0;

   // Pick the value with at most four below it and at least five not above it.
   function automatic logic [7:0] median_of(input logic [8*TAPS-1:0] taps);
      logic [7:0] a;
      logic [7:0] b;
      int         below;
      int         not_above;
      for (int i = 0; i < TAPS; i++) begin
         a = taps[8*i +: 8];
         below = 0;
         not_above = 0;
         for (int j = 0; j < TAPS; j++) begin
            b = taps[8*j +: 8];
            if (b < a) below++;
            if (b <= a) not_above++;
         end
         if (below <= TAPS / 2 && not_above > TAPS / 2) return a;
      end
      return 8'h00;
   endfunction

   task automatic filter_beat(input logic [7:0] pixel, input logic flush);
      int                w;
      int                h;
      int                r;
      int                c;
      int                cr;
      int                cc;
      logic [7:0]        v;
      logic [7:0]        top;
      logic [7:0]        mid;
      logic [8*TAPS-1:0] held;
      logic              emit;
      median_beat_type   beat;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
      h = (height_reg == 0) ? 1 :
          ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg));
      r = row_pos;
      c = col_pos;
      if (c >= w) c = 0;

      // padding rows and flush beats enter as zero
      v = (flush || r >= h) ? 8'h00 : pixel;
      mid = (r >= 1) ? middle_row[c] : 8'h00;
      top = (r >= 2) ? upper_row[c] : 8'h00;
      upper_row[c] = mid;
      middle_row[c] = v;
      for (int i = 0; i < 6; i++) window[i] = window[i+3];
      window[6] = top;
      window[7] = mid;
      window[8] = v;

      cr = 0;
      cc = 0;
      if (c >= 1) begin
         emit = (r >= 1);
         cr = r - 1;
         cc = c - 1;
      end else begin
         emit = (r >= 2);
         cr = r - 2;
         cc = w - 1;
      end

      if (emit && cr < h) begin
         for (int i = 0; i < TAPS; i++) held[8*i +: 8] = window[i];
         if (cc == 0) held[23:0] = '0;
         if (cc == w - 1) held[71:48] = '0;
         beat.median_value = median_of(held);
         beat.last_of_image = (cr == h - 1 && cc == w - 1);
         median_queue.push_back(beat);
      end

      // wrap to a new image after the single beat of the second padding row
      if (r >= h + 1) begin
         row_pos = 0;
         col_pos = 0;
      end else begin
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         col_pos = c;
         row_pos = r;
      end
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      if (errors < 100)
         $display("mismatch in %s at %0t: got %0d, expected %0d", field, $time, got, want);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      median_beat_type want;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i] = 8'h00;
            middle_row[i] = 8'h00;
         end
         for (int i = 0; i < TAPS; i++) window[i] = 8'h00;
         width_reg = WIDTH_REG_BITS'(WIDTH_RESET);
         height_reg = ROW_BITS'(HEIGHT_RESET);
         col_pos = 0;
         row_pos = 0;
         median_queue.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               width_reg = csr_write_data[WIDTH_REG_BITS-1:0];
               col_pos = 0;
               row_pos = 0;
            end else if (csr_index == CSR_IMAGE_HEIGHT) begin
               height_reg = csr_write_data[ROW_BITS-1:0];
               col_pos = 0;
               row_pos = 0;
            end
         end
         if (rsp_tap.valid && rsp_tap.ready) begin
            if (median_queue.size() == 0) begin
               report_mismatch("result beat with nothing pending", rsp_tap.median_value, -1);
            end else begin
               want = median_queue.pop_front();
               if (rsp_tap.median_value !== want.median_value)
                  report_mismatch("median_value", rsp_tap.median_value, want.median_value);
               if (rsp_tap.last_of_image !== want.last_of_image)
                  report_mismatch("last_of_image", rsp_tap.last_of_image, want.last_of_image);
            end
         end
         if (req_tap.valid && req_tap.ready)
            filter_beat(req_tap.pixel_value, req_tap.flush_item);
      end
      outstanding <= median_queue.size();
      mismatch_count <= errors;
   end

endmodule

>>> sim/tb_median_filter_3x3_stream.sv
// Testbench top for the 3x3 median filter: pixel and register stimulus, and the verdict.
module tb_median_filter_3x3_stream;
   import mf3_pkg::*;

   localparam int MAX_W          = 2048;
   localparam int CLOCK_PERIOD   = 12;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int SHORT_RUN      = 40;
   localparam int RANDOM_BEATS   = 1450;
   localparam int TIMEOUT_CYCLES = 500_000;
   // indexes past the height register select nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED = CSR_IMAGE_HEIGHT + 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAST_UNUSED  = '1;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;
   int                        outstanding;
   int                        mismatch_count;

   int beats_sent   = 0;
   int cur_w        = WIDTH_RESET;
   int cur_h        = HEIGHT_RESET;
   bit tx_quiet     = 1'b0;
   bit rx_quiet     = 1'b0;
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;

   mf3_req_if #(.PIXEL_BITS(8)) pixel_bus ();
   mf3_rsp_if #(.PIXEL_BITS(8)) median_bus ();

   median_filter_3x3_stream #(
      .MAX_WIDTH  (MAX_W),
      .PIXEL_BITS (8)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (pixel_bus),
      .rsp_bus          (median_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   median_stream_checker #(
      .MAX_WIDTH (MAX_W)
   ) median_check (
      .clock            (clock),
      .reset            (reset),
      .req_tap          (pixel_bus),
      .rsp_tap          (median_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .outstanding      (outstanding),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int pick_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 9);
      return $urandom_range(10, 24);
   endfunction

   function automatic logic [7:0] pick_pixel();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 2) return 8'h00;
      if (roll == 2) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_width();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 13) return $urandom_range(1, 6);
      if (roll < 17) return $urandom_range(7, 24);
      case (roll)
         17: return 0;
         18: return 'h1003;  // bit above the width field drops, leaves 3
         default: return $urandom_range(25, 48);
      endcase
   endfunction

   function automatic int pick_height();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 14) return $urandom_range(1, 4);
      if (roll < 19) return $urandom_range(5, 8);
      return 0;
   endfunction

   task automatic send_beat(input logic [7:0] pixel, input logic flush);
      int gap;
      gap = pick_gap(tx_quiet);
      if (gap > 0) begin
         pixel_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pixel_bus.valid <= 1'b1;
      pixel_bus.pixel_value <= pixel;
      pixel_bus.flush_item <= flush;
      @(posedge clock);
      while (!pixel_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   // Drop valid, wait for every pending median, then let the pipeline empty.
   task automatic settle();
      pixel_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index, input int value);
      settle();
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_IMAGE_WIDTH) begin
         cur_w = value & 'hFFF;
         if (cur_w == 0) cur_w = 1;
         if (cur_w > MAX_W) cur_w = MAX_W;
      end else if (index == CSR_IMAGE_HEIGHT) begin
         cur_h = value & 'h1FFF;
         if (cur_h == 0) cur_h = 1;
         if (cur_h > HEIGHT_LIMIT) cur_h = HEIGHT_LIMIT;
      end
   endtask

   // One image plus its width+1 padding beats; noisy mixes in flushes and padding pixels.
   task automatic send_image(input bit noisy, input bit cut);
      int         total;
      int         stop_at;
      logic       flush;
      logic [7:0] pixel;
      total = cur_w * cur_h + cur_w + 1;
      stop_at = cut ? $urandom_range(1, total - 1) : total;
      for (int n = 0; n < stop_at; n++) begin
         if (n < cur_w * cur_h) begin
            pixel = pick_pixel();
            flush = noisy && ($urandom_range(0, 11) == 0);
         end else begin
            flush = !(noisy && ($urandom_range(0, 3) == 0));
            pixel = flush ? 8'($urandom_range(0, 255)) : pick_pixel();
         end
         send_beat(pixel, flush);
      end
   endtask

   initial begin : result_side
      int stall;
      median_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // long hold-off so the filter backs up into its input
         if (hold_request && !hold_done) begin
            median_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         stall = pick_gap(rx_quiet);
         if (stall > 0) begin
            median_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         median_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin : stimulus
      int random_start;
      int sel;
      bit noisy;
      bit cut;
      bit need_write;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      pixel_bus.valid <= 1'b0;
      pixel_bus.pixel_value <= '0;
      pixel_bus.flush_item <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: a few beats of the first row, no medians yet
      repeat (5) send_beat(pick_pixel(), 1'b0);

      // 3x3 image: extremes, a flush inside the image, pixels in both padding rows
      write_reg(CSR_IMAGE_WIDTH, 3);
      write_reg(CSR_IMAGE_HEIGHT, 3);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h80, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h7F, 1'b1);
      send_beat(8'h00, 1'b1);
      send_beat(8'hAA, 1'b0);

      // write to an empty index changes nothing; zero sizes act as 1x1
      write_reg(CSR_LAST_UNUSED, 'h1FFF);
      write_reg(CSR_IMAGE_WIDTH, 0);
      write_reg(CSR_IMAGE_HEIGHT, 0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'hFF, 1'b0);

      // widest row (all data bits set, saturates), then tallest column (saturates):
      // the opening stretch of each, the next write realigns the counters
      write_reg(CSR_IMAGE_WIDTH, 'h1FFF);
      write_reg(CSR_IMAGE_HEIGHT, 1);
      repeat (SHORT_RUN) send_beat(pick_pixel(), 1'b0);
      write_reg(CSR_IMAGE_WIDTH, 1);
      write_reg(CSR_IMAGE_HEIGHT, 'h1FFF);
      repeat (SHORT_RUN) send_beat(pick_pixel(), 1'b0);

      // random part opens with a mid-size image under the long hold-off
      random_start = beats_sent;
      write_reg(CSR_IMAGE_WIDTH, 16);
      write_reg(CSR_IMAGE_HEIGHT, 12);
      hold_request = 1'b1;
      send_image(1'b0, 1'b0);

      need_write = 1'b1;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         if (need_write || $urandom_range(0, 1) == 1) begin
            sel = $urandom_range(0, 3);
            if (sel != 1) write_reg(CSR_IMAGE_WIDTH, pick_width());
            if (sel != 2 || !need_write) write_reg(CSR_IMAGE_HEIGHT, pick_height());
            if ($urandom_range(0, 7) == 0)
               write_reg(CSR_INDEX_BITS'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)),
                         $urandom_range(0, 'h1FFF));
         end
         need_write = 1'b0;
         repeat ($urandom_range(1, 3)) begin
            noisy = ($urandom_range(0, 9) < 3);
            cut = ($urandom_range(0, 9) == 0);
            send_image(noisy, cut);
            // a cut image leaves the counters mid-frame: realign with a write
            if (cut) begin
               need_write = 1'b1;
               break;
            end
         end
      end

      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      settle();
      if (mismatch_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_req_if.sv
rtl/mf3_rsp_if.sv
rtl/mf3_ram.sv
rtl/mf3_front.sv
rtl/mf3_queue.sv
rtl/mf3_median.sv
rtl/median_filter_3x3_stream.sv
sim/median_stream_checker.sv
sim/tb_median_filter_3x3_stream.sv
